/* rtl/bdsl_pkg.sv */
package bdsl_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS   = 2'd0,
        REG_LONG_PRESS_TICKS = 2'd1
    } cfg_reg_t;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_TICKS_RST = 16'd3000;

    // Stream payload layout
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;

    localparam int unsigned IN_RAW_LEVEL_BIT   = 0;
    localparam int unsigned OUT_DEBOUNCED_BIT  = 0;
    localparam int unsigned OUT_SHORT_PRESS_BIT = 1;
    localparam int unsigned OUT_LONG_PRESS_BIT = 2;

    // Button level codes (active low pin)
    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

endpackage

/* rtl/button_debounce_short_long_press_core.sv */
// Channel   | Dir | Signals                              | Contents
// ----------+-----+--------------------------------------+------------------------------
// s_        | in  | s_tvalid s_tready s_tdata[7:0]       | one tick: raw_level in bit 0
// m_        | out | m_tvalid m_tready m_tdata[7:0]       | debounced, short, long pulses
// cfg_      | in  | cfg_valid cfg_ready cfg_index cfg_data | register writes, always ready
//
// One tick transfer is accepted per cycle while s_tready is high. Its result passes through
// the input register, then the state update into the result register, which drives m_.
// The state update is combinational between the two: one tick per clock while m_ is not stalled.
// A stalled output holds the pipe; s_tready falls only when both stages are full.
// rst_n clears all control state and restores both registers to their defaults.
module button_debounce_short_long_press_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Tick input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdsl_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] raw_level, [7:1] zero
    // Result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdsl_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] debounced_level,
                                                           // [1] short_press,
                                                           // [2] long_press, [7:3] zero
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdsl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bdsl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > bdsl_pkg::CFG_DATA_W) ?
                                    COUNT_WIDTH : bdsl_pkg::CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

    // Configuration registers
    logic [bdsl_pkg::CFG_DATA_W-1:0] debounce_ticks_reg;
    logic [bdsl_pkg::CFG_DATA_W-1:0] long_press_ticks_reg;

    // Pipeline registers
    logic       in_valid_reg;
    logic       in_raw_reg;
    logic       out_valid_reg;
    logic [2:0] out_bits_reg;

    // Button state
    logic                   last_raw_reg,   last_raw_next;
    logic                   accepted_reg,   accepted_next;
    logic [COUNT_WIDTH-1:0] stable_cnt_reg, stable_cnt_next;
    logic [COUNT_WIDTH-1:0] press_cnt_reg,  press_cnt_next;
    logic                   pressing_reg,   pressing_next;
    logic                   long_fired_reg, long_fired_next;
    logic                   short_pulse, long_pulse;

    logic                   advance;
    logic                   take_in;
    logic [COUNT_WIDTH-1:0] press_cnt_inc;
    logic                   level_ok;

    // Handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign take_in   = s_tvalid && s_tready;
    assign s_tready  = !in_valid_reg || !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[bdsl_pkg::OUT_DEBOUNCED_BIT]   = out_bits_reg[0];
        m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT] = out_bits_reg[1];
        m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT]  = out_bits_reg[2];
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg   <= bdsl_pkg::DEBOUNCE_TICKS_RST;
            long_press_ticks_reg <= bdsl_pkg::LONG_PRESS_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bdsl_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_data;
                bdsl_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tick update: counters, debounce accept, press classification
    always_comb
    begin
        press_cnt_inc = press_cnt_reg;
        if (pressing_reg && (press_cnt_reg != CNT_MAX))
            press_cnt_inc = press_cnt_reg + CNT_ONE;

        if (in_raw_reg != last_raw_reg)
            stable_cnt_next = '0;
        else if (stable_cnt_reg != CNT_MAX)
            stable_cnt_next = stable_cnt_reg + CNT_ONE;
        else
            stable_cnt_next = stable_cnt_reg;

        level_ok = CMP_W'(stable_cnt_next) > CMP_W'(debounce_ticks_reg);

        last_raw_next   = in_raw_reg;
        accepted_next   = accepted_reg;
        press_cnt_next  = press_cnt_inc;
        pressing_next   = pressing_reg;
        long_fired_next = long_fired_reg;
        short_pulse     = 1'b0;
        long_pulse      = 1'b0;

        if (level_ok)
        begin
            accepted_next = in_raw_reg;
            if (in_raw_reg == bdsl_pkg::LEVEL_PRESSED)
            begin
                if (!pressing_reg && !long_fired_reg)
                begin
                    press_cnt_next = '0;
                    pressing_next  = 1'b1;
                end
                else if ((CMP_W'(press_cnt_inc) > CMP_W'(long_press_ticks_reg))
                         && !long_fired_reg)
                begin
                    long_fired_next = 1'b1;
                    long_pulse      = 1'b1;
                end
            end
            else if (pressing_reg)
            begin
                pressing_next   = 1'b0;
                long_fired_next = 1'b0;
                short_pulse     = !long_fired_reg;
            end
        end
    end

    // Pipeline and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_raw_reg   <= bdsl_pkg::LEVEL_RELEASED;
            accepted_reg   <= bdsl_pkg::LEVEL_RELEASED;
            stable_cnt_reg <= '0;
            press_cnt_reg  <= '0;
            pressing_reg   <= 1'b0;
            long_fired_reg <= 1'b0;
        end
        else
        begin
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                last_raw_reg   <= last_raw_next;
                accepted_reg   <= accepted_next;
                stable_cnt_reg <= stable_cnt_next;
                press_cnt_reg  <= press_cnt_next;
                pressing_reg   <= pressing_next;
                long_fired_reg <= long_fired_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
            in_raw_reg <= s_tdata[bdsl_pkg::IN_RAW_LEVEL_BIT];
        if (advance)
            out_bits_reg <= {long_pulse, short_pulse, accepted_next};
    end

endmodule

/* rtl/bdsl_checker.sv */
module bdsl_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [bdsl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // Short and long pulses never share a result
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT] &&
                       m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT]))
        else $error("short and long press in one result");

    // A short press is reported only together with a released level
    a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT])
        |-> (m_tdata[bdsl_pkg::OUT_DEBOUNCED_BIT] == bdsl_pkg::LEVEL_RELEASED))
        else $error("short press while level pressed");

    // A long press fires only while the level is pressed
    a_long_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT])
        |-> (m_tdata[bdsl_pkg::OUT_DEBOUNCED_BIT] == bdsl_pkg::LEVEL_PRESSED))
        else $error("long press while level released");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind button_debounce_short_long_press_core bdsl_checker u_bdsl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* verif/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CNT_W        = 16;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned LIMIT_CYCLES = 2_000_000;

    // Indexes outside the register map; writes to them must be dropped
    localparam logic [bdsl_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_2 = 2'd2;
    localparam logic [bdsl_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_3 = 2'd3;

    typedef struct packed {
        logic long_press;
        logic short_press;
        logic debounced;
    } press_result_t;

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [bdsl_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [bdsl_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [bdsl_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bdsl_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor copy of the debouncer state and registers
    logic [bdsl_pkg::CFG_DATA_W-1:0] debounce_cfg;
    logic [bdsl_pkg::CFG_DATA_W-1:0] long_cfg;
    logic                            last_raw_q;
    logic                            accepted_q;
    logic [CNT_W-1:0]                stable_cnt;
    logic [CNT_W-1:0]                press_cnt;
    logic                            pressing_q;
    logic                            long_fired_q;

    press_result_t pending_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        hold_off      = 1'b0;
    event        hold_trig;

    int unsigned mismatch_count = 0;
    int unsigned ticks_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned shorts_seen    = 0;
    int unsigned longs_seen     = 0;
    int unsigned reg_writes     = 0;
    int unsigned cycle_count    = 0;

    button_debounce_short_long_press_core #(
        .COUNT_WIDTH(CNT_W)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // One tick of the debouncer: updates predictor state, returns the result
    function automatic press_result_t debounce_tick(input logic raw);
        press_result_t r;
        r = '0;
        if (pressing_q)
            press_cnt = sat_inc(press_cnt);
        if (raw != last_raw_q)
            stable_cnt = '0;
        else
            stable_cnt = sat_inc(stable_cnt);
        if (stable_cnt > debounce_cfg)
        begin
            accepted_q = raw;
            if (accepted_q == bdsl_pkg::LEVEL_PRESSED)
            begin
                if (!pressing_q && !long_fired_q)
                begin
                    press_cnt  = '0;
                    pressing_q = 1'b1;
                end
                else if (press_cnt > long_cfg && !long_fired_q)
                begin
                    long_fired_q = 1'b1;
                    r.long_press = 1'b1;
                end
            end
            else if (pressing_q)
            begin
                pressing_q = 1'b0;
                if (long_fired_q)
                    long_fired_q = 1'b0;
                else
                    r.short_press = 1'b1;
            end
        end
        last_raw_q  = raw;
        r.debounced = accepted_q;
        return r;
    endfunction

    // Receiver: random stalls, or a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_trig);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        press_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT])
                shorts_seen++;
            if (m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT])
                longs_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing pending: m_tdata=%h", m_tdata);
                mismatch_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_tdata[bdsl_pkg::OUT_DEBOUNCED_BIT] !== exp_r.debounced)
                begin
                    $error("debounced_level: expected %0b, got %0b",
                           exp_r.debounced, m_tdata[bdsl_pkg::OUT_DEBOUNCED_BIT]);
                    mismatch_count++;
                end
                if (m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT] !== exp_r.short_press)
                begin
                    $error("short_press: expected %0b, got %0b",
                           exp_r.short_press, m_tdata[bdsl_pkg::OUT_SHORT_PRESS_BIT]);
                    mismatch_count++;
                end
                if (m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT] !== exp_r.long_press)
                begin
                    $error("long_press: expected %0b, got %0b",
                           exp_r.long_press, m_tdata[bdsl_pkg::OUT_LONG_PRESS_BIT]);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one tick, wait for the transfer, record its expected result
    task automatic send_tick(input logic lvl);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bdsl_pkg::IN_TDATA_W'(lvl);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        ticks_sent++;
        pending_results.push_back(debounce_tick(lvl));
    endtask

    task automatic send_run(input logic lvl, input int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    task automatic send_bounce(input int unsigned n);
        repeat (n) send_tick(1'($urandom_range(0, 1)));
    endtask

    // Let the pipe empty so registers can be written safely
    task automatic wait_idle;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bdsl_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bdsl_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bdsl_pkg::REG_DEBOUNCE_TICKS:   debounce_cfg = val;
            bdsl_pkg::REG_LONG_PRESS_TICKS: long_cfg     = val;
            default: ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One press shaped around the current thresholds: bounce, hold, bounce, release
    task automatic send_press;
        int unsigned d;
        int unsigned l;
        int unsigned hold_len;
        int unsigned rel_len;
        d = (debounce_cfg < 80) ? debounce_cfg : 20;
        l = (long_cfg < 80) ? long_cfg : 10;
        if ($urandom_range(0, 3) == 0)
            hold_len = $urandom_range(0, d + 4);
        else
            hold_len = d + $urandom_range(1, l + 6);
        if ($urandom_range(0, 3) == 0)
            rel_len = $urandom_range(0, d + 4);
        else
            rel_len = d + $urandom_range(1, 4);
        send_bounce($urandom_range(0, 3));
        send_run(bdsl_pkg::LEVEL_PRESSED, hold_len);
        send_bounce($urandom_range(0, 3));
        send_run(bdsl_pkg::LEVEL_RELEASED, rel_len);
    endtask

    // Reset values: 50-tick debounce, press then release
    task automatic test_reset_values;
        send_run(bdsl_pkg::LEVEL_PRESSED, 52);
        send_run(bdsl_pkg::LEVEL_RELEASED, 52);
        wait_idle();
    endtask

    // Zero debounce, long press, short press, bouncing, unmapped writes,
    // and a debounce setting that can never be met
    task automatic test_directed_cases;
        write_reg(bdsl_pkg::REG_DEBOUNCE_TICKS, 16'd0);
        write_reg(bdsl_pkg::REG_LONG_PRESS_TICKS, 16'd2);
        send_run(bdsl_pkg::LEVEL_PRESSED, 6);
        send_run(bdsl_pkg::LEVEL_RELEASED, 2);
        send_run(bdsl_pkg::LEVEL_PRESSED, 3);
        send_run(bdsl_pkg::LEVEL_RELEASED, 2);
        repeat (2)
        begin
            send_tick(bdsl_pkg::LEVEL_PRESSED);
            send_tick(bdsl_pkg::LEVEL_RELEASED);
        end
        wait_idle();
        write_reg(REG_UNMAPPED_2, 16'hFFFF);
        write_reg(REG_UNMAPPED_3, 16'h0000);
        send_run(bdsl_pkg::LEVEL_PRESSED, 2);
        send_run(bdsl_pkg::LEVEL_RELEASED, 2);
        wait_idle();
        write_reg(bdsl_pkg::REG_DEBOUNCE_TICKS, 16'hFFFF);
        send_run(bdsl_pkg::LEVEL_PRESSED, 3);
        wait_idle();
    endtask

    // Output held off for a long stretch while ticks keep coming
    task automatic test_output_stall;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(bdsl_pkg::REG_DEBOUNCE_TICKS, 16'd1);
        write_reg(bdsl_pkg::REG_LONG_PRESS_TICKS, 16'd3);
        -> hold_trig;
        repeat (3)
        begin
            send_run(bdsl_pkg::LEVEL_PRESSED, 9);
            send_run(bdsl_pkg::LEVEL_RELEASED, 4);
            send_run(bdsl_pkg::LEVEL_PRESSED, 3);
            send_run(bdsl_pkg::LEVEL_RELEASED, 4);
        end
        wait_idle();
    endtask

    // Random settings, mostly well-formed presses, some pure noise
    task automatic test_random_presses(input int unsigned snd_pct,
                                       input int unsigned rcv_pct,
                                       input int unsigned n_ticks);
        int unsigned stop_at;
        int unsigned sel;
        logic [bdsl_pkg::CFG_DATA_W-1:0] dbn;
        logic [bdsl_pkg::CFG_DATA_W-1:0] lng;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            wait_idle();
            sel = $urandom_range(0, 99);
            if (sel < 70)
                dbn = bdsl_pkg::CFG_DATA_W'($urandom_range(0, 4));
            else if (sel < 90)
                dbn = bdsl_pkg::CFG_DATA_W'($urandom_range(5, 20));
            else
                dbn = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd0;
            sel = $urandom_range(0, 99);
            if (sel < 70)
                lng = bdsl_pkg::CFG_DATA_W'($urandom_range(0, 12));
            else if (sel < 90)
                lng = bdsl_pkg::CFG_DATA_W'($urandom_range(13, 40));
            else if (sel < 95)
                lng = 16'd0;
            else
                lng = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'hFFFE;
            write_reg(bdsl_pkg::REG_DEBOUNCE_TICKS, dbn);
            write_reg(bdsl_pkg::REG_LONG_PRESS_TICKS, lng);
            repeat ($urandom_range(2, 5))
            begin
                if ($urandom_range(0, 99) < 15)
                    send_bounce($urandom_range(1, 20));
                else
                    send_press();
            end
        end
        wait_idle();
    endtask

    initial
    begin
        // Predictor starts from the reset state
        debounce_cfg = bdsl_pkg::DEBOUNCE_TICKS_RST;
        long_cfg     = bdsl_pkg::LONG_PRESS_TICKS_RST;
        last_raw_q   = bdsl_pkg::LEVEL_RELEASED;
        accepted_q   = bdsl_pkg::LEVEL_RELEASED;
        stable_cnt   = '0;
        press_cnt    = '0;
        pressing_q   = 1'b0;
        long_fired_q = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_directed_cases();
        test_random_presses(11, 55, 550);
        test_random_presses(55, 11, 550);
        test_output_stall();
        test_random_presses(0, 0, 550);

        wait_idle();
        repeat (5) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("Sent %0d ticks over %0d register writes; checked %0d results",
                 ticks_sent, reg_writes, results_seen);
        $display("Saw %0d short and %0d long press pulses, %0d mismatches",
                 shorts_seen, longs_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
